// ----- rtl/core/pce_pkg.sv -----
// Shared types, character class codes and helpers of the path character escaper.
package pce_pkg;

   localparam int MaxBytes = 10;
   localparam int CountWidth = $clog2(MaxBytes + 1);

   localparam logic [2:0] CLS_CTRL   = 3'd0;
   localparam logic [2:0] CLS_LONG   = 3'd1;
   localparam logic [2:0] CLS_PREFIX = 3'd2;
   localparam logic [2:0] CLS_UTF1   = 3'd3;
   localparam logic [2:0] CLS_UTF2   = 3'd4;
   localparam logic [2:0] CLS_UTF3   = 3'd5;
   localparam logic [2:0] CLS_UTF4   = 3'd6;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_PIPE      = 8'h7c;
   localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
   localparam logic [7:0] CHAR_UPPER_U   = 8'h55;

   // One character's output bytes, first byte at index 0.
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [CountWidth-1:0]    count;
      logic                     eop;
   } pce_frame_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] res;
      if (nib < 4'd10) begin
         res = 8'h30 + {4'd0, nib};
      end else begin
         res = 8'h57 + {4'd0, nib};
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/pce_serializer.sv -----
// Holds one character's byte run and hands it out one byte per transfer.
module pce_serializer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   frame_valid,
   input  pce_pkg::pce_frame_type frame,
   output logic                   frame_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last_of_char,
   output logic                   rsp_last_of_path
);
   import pce_pkg::*;

   logic                     valid_ff, valid_in;
   logic [MaxBytes-1:0][7:0] bytes_ff, bytes_in;
   logic [CountWidth-1:0]    count_ff, count_in;
   logic                     eop_ff, eop_in;
   logic                     taken;
   logic                     on_last;
   logic                     load;

   assign on_last     = (count_ff == CountWidth'(1));
   assign taken       = valid_ff && !rsp_stall;
   assign frame_ready = !valid_ff || (taken && on_last);
   assign load        = frame_ready && frame_valid;

   always_comb begin
      valid_in = valid_ff;
      bytes_in = bytes_ff;
      count_in = count_ff;
      eop_in   = eop_ff;
      if (load) begin
         valid_in = 1'b1;
         bytes_in = frame.bytes;
         count_in = frame.count;
         eop_in   = frame.eop;
      end else if (taken) begin
         if (on_last) begin
            valid_in = 1'b0;
         end else begin
            // Shift the run down so the next byte sits at the output.
            bytes_in = {8'h00, bytes_ff[MaxBytes-1:1]};
            count_in = count_ff - CountWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      count_ff <= count_in;
      eop_ff   <= eop_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = bytes_ff[0];
   assign rsp_last_of_char = on_last;
   assign rsp_last_of_path = on_last && eop_ff;

endmodule

// ----- rtl/core/path_char_escaper_unit.sv -----
// Top level of the path character escaper: escapes or UTF-8 encodes one code point per item.
//
// Input channel req_: one decoded code point and an end-of-path flag per transfer.
// Result channel rsp_: one output byte per transfer, with flags marking the last
// byte of the character and the last byte of the path.
// Each character yields 1 to 10 bytes: control characters give four, long escapes
// ten, a backslash or pipe two, and plain characters their UTF-8 length.
// The first byte of a character reaches the result port after its input transfer has
// loaded the input register and the character has passed classification, byte build
// and the output register, in that order.
// Throughput is one character per cycle while each yields a single byte and the receiver
// does not stall; a longer character occupies the output register until its last byte is
// taken, holding the next in the build stage. The one-byte-wide result port sets that limit.
// When the receiver stalls, the output byte holds and the three pipeline stages
// fill up; req_stall rises once they are all full. Nothing is lost or repeated.
// Reset empties every stage; no output is valid afterwards until new input arrives.
module path_char_escaper_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_code_point,
   input  logic        req_end_of_path,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_char,
   output logic        rsp_last_of_path
);
   import pce_pkg::*;

   logic          s1_valid_ff, s1_valid_in;
   logic [31:0]   s1_cp_ff;
   logic          s1_eop_ff;
   logic          s2_valid_ff, s2_valid_in;
   logic [31:0]   s2_cp_ff;
   logic [2:0]    s2_cls_ff, s2_cls_in;
   logic          s2_eop_ff;
   logic          s3_valid_ff, s3_valid_in;
   pce_frame_type s3_frame_ff, s3_frame_in;
   logic          ser_ready;
   logic          s1_ready, s2_ready, s3_ready;
   logic          is_control, is_long;
   logic [15:0]   low16;

   assign s3_ready  = !s3_valid_ff || ser_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   // Classification of the registered code point.
   assign low16 = s1_cp_ff[15:0];

   always_comb begin
      is_control = (s1_cp_ff <= 32'h1f) || (s1_cp_ff >= 32'h7f && s1_cp_ff <= 32'h9f);
      is_long = (s1_cp_ff >= 32'h2028 && s1_cp_ff <= 32'h2029)
             || (s1_cp_ff >= 32'hd800 && s1_cp_ff <= 32'hdfff)
             || (s1_cp_ff == 32'he000)
             || (s1_cp_ff == 32'hf8ff)
             || (s1_cp_ff >= 32'hfdd0 && s1_cp_ff <= 32'hfddf)
             || (low16 >= 16'hfffe)
             || (s1_cp_ff == 32'hf0000)
             || (s1_cp_ff == 32'hffffd)
             || (s1_cp_ff == 32'h100000)
             || (s1_cp_ff >= 32'h10fffd);
      priority if (is_control) begin
         s2_cls_in = CLS_CTRL;
      end else if (is_long) begin
         s2_cls_in = CLS_LONG;
      end else if (s1_cp_ff == {24'd0, CHAR_BACKSLASH} || s1_cp_ff == {24'd0, CHAR_PIPE}) begin
         s2_cls_in = CLS_PREFIX;
      end else if (s1_cp_ff < 32'h80) begin
         s2_cls_in = CLS_UTF1;
      end else if (s1_cp_ff < 32'h800) begin
         s2_cls_in = CLS_UTF2;
      end else if (s1_cp_ff < 32'h10000) begin
         s2_cls_in = CLS_UTF3;
      end else begin
         s2_cls_in = CLS_UTF4;
      end
   end

   // Byte run for the classified character.
   always_comb begin
      s3_frame_in       = '0;
      s3_frame_in.eop   = s2_eop_ff;
      unique case (s2_cls_ff)
         CLS_CTRL: begin
            s3_frame_in.bytes[0] = CHAR_BACKSLASH;
            s3_frame_in.bytes[1] = CHAR_LOWER_X;
            s3_frame_in.bytes[2] = hex_char(s2_cp_ff[7:4]);
            s3_frame_in.bytes[3] = hex_char(s2_cp_ff[3:0]);
            s3_frame_in.count    = CountWidth'(4);
         end
         CLS_LONG: begin
            s3_frame_in.bytes[0] = CHAR_BACKSLASH;
            s3_frame_in.bytes[1] = CHAR_UPPER_U;
            for (int i = 0; i < 8; i++) begin
               s3_frame_in.bytes[2 + i] = hex_char(s2_cp_ff[4*(7-i) +: 4]);
            end
            s3_frame_in.count = CountWidth'(10);
         end
         CLS_PREFIX: begin
            s3_frame_in.bytes[0] = CHAR_BACKSLASH;
            s3_frame_in.bytes[1] = s2_cp_ff[7:0];
            s3_frame_in.count    = CountWidth'(2);
         end
         CLS_UTF1: begin
            s3_frame_in.bytes[0] = s2_cp_ff[7:0];
            s3_frame_in.count    = CountWidth'(1);
         end
         CLS_UTF2: begin
            s3_frame_in.bytes[0] = {3'b110, s2_cp_ff[10:6]};
            s3_frame_in.bytes[1] = {2'b10, s2_cp_ff[5:0]};
            s3_frame_in.count    = CountWidth'(2);
         end
         CLS_UTF3: begin
            s3_frame_in.bytes[0] = {4'b1110, s2_cp_ff[15:12]};
            s3_frame_in.bytes[1] = {2'b10, s2_cp_ff[11:6]};
            s3_frame_in.bytes[2] = {2'b10, s2_cp_ff[5:0]};
            s3_frame_in.count    = CountWidth'(3);
         end
         default: begin
            s3_frame_in.bytes[0] = {5'b11110, s2_cp_ff[20:18]};
            s3_frame_in.bytes[1] = {2'b10, s2_cp_ff[17:12]};
            s3_frame_in.bytes[2] = {2'b10, s2_cp_ff[11:6]};
            s3_frame_in.bytes[3] = {2'b10, s2_cp_ff[5:0]};
            s3_frame_in.count    = CountWidth'(4);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_cp_ff  <= req_code_point;
         s1_eop_ff <= req_end_of_path;
      end
      if (s2_ready) begin
         s2_cp_ff  <= s1_cp_ff;
         s2_cls_ff <= s2_cls_in;
         s2_eop_ff <= s1_eop_ff;
      end
      if (s3_ready) begin
         s3_frame_ff <= s3_frame_in;
      end
   end

   pce_serializer u_serializer (
      .clock            (clock),
      .reset            (reset),
      .frame_valid      (s3_valid_ff),
      .frame            (s3_frame_ff),
      .frame_ready      (ser_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_char (rsp_last_of_char),
      .rsp_last_of_path (rsp_last_of_path)
   );

`ifndef SYNTHESIS
   // A built byte run always carries between one and ten bytes.
   a_frame_count: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_frame_ff.count >= CountWidth'(1)
                       && s3_frame_ff.count <= CountWidth'(MaxBytes)))
      else $error("byte run count out of range");

   // A character waiting in the build stage stays there until the serializer takes it.
   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !ser_ready) |=> (s3_valid_ff && $stable(s3_frame_ff)))
      else $error("build stage lost a waiting character");

   // The path end flag only ever marks the last byte of a character.
   a_path_on_char_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_path) |-> rsp_last_of_char)
      else $error("path end flagged before the end of a character");
`endif

endmodule
